// File: rtl/core/bsm_pkg.sv
package bsm_pkg;

    // Result targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PRG  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;
    localparam logic [1:0] TGT_CHR  = 2'd3;

    // Event modes
    localparam logic [2:0] MODE_CPU_RD = 3'd0;
    localparam logic [2:0] MODE_CPU_WR = 3'd1;
    localparam logic [2:0] MODE_CHR_RD = 3'd2;
    localparam logic [2:0] MODE_CHR_WR = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_RAM_PRES  = 2'd2;
    localparam logic [1:0] CFG_INIT_MIR  = 2'd3;

    localparam logic [8:0] MAX_BANKS = 9'd256;

    // Mapper state as seen by the datapath
    typedef struct packed {
        logic [8:0]      prg_count;
        logic [8:0]      chr_count;
        logic            ram_present;
        logic [7:0]      bank_select;
        logic [7:0][7:0] bank_regs;
        logic            ram_enable;
        logic            ram_protect;
        logic            irq_flag;
        logic            mirror;
    } map_state_t;

    // State update commanded by an accepted item
    typedef struct packed {
        logic        reg_wr;
        logic        tick;
        logic [15:0] addr;
        logic [7:0]  data;
    } map_cmd_t;

    // Limit a bank count to the 256 banks that an 8-bit register reaches
    function automatic logic [8:0] clamp_count(input logic [8:0] c);
        clamp_count = (c > MAX_BANKS) ? MAX_BANKS : c;
    endfunction

endpackage

// File: rtl/core/bsm_rem_unit.sv
module bsm_rem_unit
    import bsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [8:0] divisor,
    output logic       done,
    output logic [7:0] rem
);

    logic [7:0] rem_reg;
    logic [7:0] div_reg;
    logic [8:0] dsr_reg;
    logic [1:0] cnt_reg;
    logic       busy_reg;
    logic       done_reg;

    logic [8:0] r1;
    logic [8:0] r1_sub;
    logic [8:0] r2;
    logic [8:0] r2_sub;

    // Two restoring steps per cycle, dividend MSB first
    always_comb
    begin
        r1     = {rem_reg, div_reg[7]};
        r1_sub = (r1 >= dsr_reg) ? (r1 - dsr_reg) : r1;
        r2     = {r1_sub[7:0], div_reg[6]};
        r2_sub = (r2 >= dsr_reg) ? (r2 - dsr_reg) : r2;
    end

    // Load on start, then advance while busy and pulse done at the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 8'd0;
            div_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2_sub[7:0];
            div_reg <= {div_reg[5:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/bsm_state.sv
module bsm_state
    import bsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       cmd_valid,
    input  map_cmd_t   cmd,
    output map_state_t st
);

    logic [8:0]      prg_count_reg;
    logic [8:0]      chr_count_reg;
    logic            ram_present_reg;
    logic [7:0]      bank_select_reg;
    logic [7:0][7:0] bank_regs_reg;
    logic            ram_enable_reg;
    logic            ram_protect_reg;
    logic [7:0]      irq_latch_reg;
    logic [7:0]      irq_count_reg;
    logic            irq_reload_reg;
    logic            irq_enable_reg;
    logic            irq_flag_reg;
    logic            mirror_reg;

    logic [7:0]      irq_count_next;
    logic            odd;

    assign odd = cmd.addr[0];

    // Reload or decrement the scanline counter
    always_comb
    begin
        if ((irq_count_reg == 8'd0) || irq_reload_reg)
            irq_count_next = irq_latch_reg;
        else
            irq_count_next = irq_count_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg   <= 9'd32;
            chr_count_reg   <= 9'd128;
            ram_present_reg <= 1'b1;
            bank_select_reg <= 8'd0;
            bank_regs_reg   <= '0;
            ram_enable_reg  <= 1'b1;
            ram_protect_reg <= 1'b0;
            irq_latch_reg   <= 8'd0;
            irq_count_reg   <= 8'd0;
            irq_reload_reg  <= 1'b0;
            irq_enable_reg  <= 1'b0;
            irq_flag_reg    <= 1'b0;
            mirror_reg      <= 1'b0;
        end
        else
        begin
            // Configuration writes; the initial mirroring loads the live mirroring
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_PRG_COUNT: prg_count_reg   <= cfg_data;
                    CFG_CHR_COUNT: chr_count_reg   <= cfg_data;
                    CFG_RAM_PRES:  ram_present_reg <= cfg_data[0];
                    CFG_INIT_MIR:  mirror_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            // Mapper register writes, decoded by window and address parity
            if (cmd_valid && cmd.reg_wr)
            begin
                case (cmd.addr[14:13])
                    2'd0:
                    begin
                        if (!odd)
                            bank_select_reg <= cmd.data;
                        else
                            bank_regs_reg[bank_select_reg[2:0]] <= cmd.data;
                    end
                    2'd1:
                    begin
                        if (!odd)
                            mirror_reg <= cmd.data[0];
                        else
                        begin
                            ram_protect_reg <= cmd.data[6];
                            ram_enable_reg  <= cmd.data[7];
                        end
                    end
                    2'd2:
                    begin
                        if (!odd)
                            irq_latch_reg <= cmd.data;
                        else
                        begin
                            irq_count_reg  <= 8'd0;
                            irq_reload_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!odd)
                        begin
                            irq_enable_reg <= 1'b0;
                            irq_flag_reg   <= 1'b0;
                        end
                        else
                            irq_enable_reg <= 1'b1;
                    end
                endcase
            end
            // Scanline tick
            if (cmd_valid && cmd.tick)
            begin
                irq_count_reg  <= irq_count_next;
                irq_reload_reg <= 1'b0;
                if ((irq_count_next == 8'd0) && irq_enable_reg)
                    irq_flag_reg <= 1'b1;
            end
        end
    end

    assign st.prg_count   = clamp_count(prg_count_reg);
    assign st.chr_count   = clamp_count(chr_count_reg);
    assign st.ram_present = ram_present_reg;
    assign st.bank_select = bank_select_reg;
    assign st.bank_regs   = bank_regs_reg;
    assign st.ram_enable  = ram_enable_reg;
    assign st.ram_protect = ram_protect_reg;
    assign st.irq_flag    = irq_flag_reg;
    assign st.mirror      = mirror_reg;

endmodule

// File: rtl/core/bank_switch_mapper_with_scanline_irq_core.sv
// Flow: register writes, ticks and work-RAM or blocked accesses pass from the
// input beat through the finish state to the output register; ROM and pattern
// accesses first wait in the calc state for the shared remainder unit, which
// reduces the bank number two bits per cycle. No new item is taken before the last is through: the input
// is not ready while busy, and a stalled result holds the sequencer.
// Reset: rst_n clears all mapper state to its power-on values at once.
module bank_switch_mapper_with_scanline_irq_core
    import bsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] addr, [23:16] data
    input  logic [2:0]  s_tuser,    // [2:0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] mem_address, [21] write_strobe,
                                    // [22] irq, [23] mirror_horizontal
    output logic [1:0]  m_tuser,    // [1:0] target
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [1:0]  tgt_reg;
    logic        strobe_reg;
    logic [12:0] low_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [1:0]  out_user_reg;

    map_state_t  st;
    map_cmd_t    cmd;
    logic        accept;
    logic [2:0]  mode;
    logic [15:0] addr;
    logic [7:0]  data;

    logic [1:0]  tgt;
    logic        strobe;
    logic        need_rem;
    logic [7:0]  bank;
    logic [8:0]  count;
    logic        ram_ok;

    logic [1:0]  win;
    logic [7:0]  prg_second;
    logic [7:0]  prg_bank;
    logic [2:0]  slot;
    logic [7:0]  chr_bank;

    logic        rem_done;
    logic [7:0]  rem;
    logic        fin_go;
    logic [20:0] maddr;

    assign mode   = s_tuser;
    assign addr   = s_tdata[15:0];
    assign data   = s_tdata[23:16];
    assign accept = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Program bank select: swap the first and third windows in swap mode
    always_comb
    begin
        win = addr[14:13];
        if (st.bank_select[6] && !win[0])
            win = win ^ 2'b10;
        prg_second = (st.prg_count >= 9'd2) ? 8'(st.prg_count - 9'd2) : 8'd0;
        case (win)
            2'd0:    prg_bank = st.bank_regs[6];
            2'd1:    prg_bank = st.bank_regs[7];
            2'd2:    prg_bank = prg_second;
            default: prg_bank = 8'(st.prg_count - 9'd1);
        endcase
    end

    // Pattern bank select: 2 KiB pairs in the low half, 1 KiB slots above
    always_comb
    begin
        slot = addr[12:10] ^ {st.bank_select[7], 2'b00};
        if (!slot[2])
            chr_bank = {st.bank_regs[{1'b0, slot[2:1]}][7:1], slot[0]};
        else
            chr_bank = st.bank_regs[slot - 3'd2];
    end

    // Decode the event
    always_comb
    begin
        tgt      = TGT_NONE;
        strobe   = 1'b0;
        need_rem = 1'b0;
        bank     = prg_bank;
        count    = st.prg_count;
        cmd.reg_wr = 1'b0;
        cmd.tick   = 1'b0;
        cmd.addr   = addr;
        cmd.data   = data;
        ram_ok   = st.ram_present && st.ram_enable &&
                   !((mode == MODE_CPU_WR) && st.ram_protect);
        case (mode)
            MODE_CPU_RD, MODE_CPU_WR:
            begin
                if (addr[15:13] == 3'b011)
                begin
                    if (ram_ok)
                    begin
                        tgt    = TGT_RAM;
                        strobe = (mode == MODE_CPU_WR);
                    end
                end
                else if (addr[15])
                begin
                    if (mode == MODE_CPU_WR)
                        cmd.reg_wr = 1'b1;
                    else if (st.prg_count != 9'd0)
                    begin
                        tgt      = TGT_PRG;
                        need_rem = 1'b1;
                    end
                end
            end
            MODE_CHR_RD, MODE_CHR_WR:
            begin
                bank  = chr_bank;
                count = st.chr_count;
                if (st.chr_count != 9'd0)
                begin
                    tgt      = TGT_CHR;
                    strobe   = (mode == MODE_CHR_WR);
                    need_rem = 1'b1;
                end
            end
            MODE_TICK:
                cmd.tick = 1'b1;
            default: ;
        endcase
    end

    bsm_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (accept),
        .cmd       (cmd),
        .st        (st)
    );

    bsm_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && need_rem),
        .dividend (bank),
        .divisor  (count),
        .done     (rem_done),
        .rem      (rem)
    );

    // Sequencer
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = need_rem ? ST_CALC : ST_FIN;
            ST_CALC:
                if (rem_done)
                    state_next = ST_FIN;
            ST_FIN:
                if (fin_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the decoded item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tgt_reg    <= tgt;
            strobe_reg <= strobe;
            low_reg    <= addr[12:0];
        end
    end

    // Compose the translated address
    always_comb
    begin
        case (tgt_reg)
            TGT_PRG: maddr = {rem, low_reg};
            TGT_RAM: maddr = {8'd0, low_reg};
            TGT_CHR: maddr = {3'd0, rem, low_reg[9:0]};
            default: maddr = 21'd0;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_go)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_data_reg <= {st.mirror, st.irq_flag, strobe_reg, maddr};
            out_user_reg <= tgt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: dv/tb_bank_switch_mapper_with_scanline_irq_core.sv
`timescale 1ns / 100ps

module tb_bank_switch_mapper_with_scanline_irq_core;
    import bsm_pkg::*;

    // Mapper register addresses on the CPU bus
    localparam logic [15:0] ADDR_RAM_BASE   = 16'h6000;
    localparam logic [15:0] ADDR_BANK_SEL   = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
    localparam logic [15:0] ADDR_RAM_CTRL   = 16'hA001;
    localparam logic [15:0] ADDR_IRQ_LATCH  = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_DIS    = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_EN     = 16'hE001;

    // Bank select and RAM control bits
    localparam logic [7:0] SEL_PRG_SWAP  = 8'h40;
    localparam logic [7:0] SEL_CHR_SWAP  = 8'h80;
    localparam logic [7:0] RAM_CTRL_WP   = 8'h40;
    localparam logic [7:0] RAM_CTRL_EN   = 8'h80;

    localparam int unsigned PRG_BANK_BYTES = 8192;
    localparam int unsigned CHR_BANK_BYTES = 1024;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]  target;
        logic [20:0] mem_address;
        logic        write_strobe;
        logic        irq;
        logic        mirror_horizontal;
    } map_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = MODE_CPU_RD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PRG_COUNT;
    logic [8:0]  cfg_data = '0;

    // Mapper copy: configuration
    logic [8:0] c_prg_count = 9'd32;
    logic [8:0] c_chr_count = 9'd128;
    logic       c_ram_pres  = 1'b1;

    // Mapper copy: state
    logic [7:0] m_bank_sel    = '0;
    logic [7:0] m_banks [8]   = '{default: 8'h00};
    logic       m_ram_en      = 1'b1;
    logic       m_ram_wp      = 1'b0;
    logic [7:0] m_irq_latch   = '0;
    logic [7:0] m_irq_cnt     = '0;
    logic       m_irq_reload  = 1'b0;
    logic       m_irq_en      = 1'b0;
    logic       m_irq_pend    = 1'b0;
    logic       m_mirror      = 1'b0;

    map_result_t due_xlat [$];

    int src_idle_pct = 20;
    int dst_idle_pct = 65;
    int items_sent   = 0;
    int results_seen = 0;
    int irq_results  = 0;
    int cfg_writes   = 0;
    int errors       = 0;
    int target_hits [4] = '{default: 0};

    bank_switch_mapper_with_scanline_irq_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] addr, [23:16] data
        .s_tuser   (s_tuser),     // [2:0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [20:0] mem_address, [21] write_strobe,
                                  // [22] irq, [23] mirror_horizontal
        .m_tuser   (m_tuser),     // [1:0] target
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Translate a program ROM address through the current window layout
    function automatic logic [20:0] prg_offset(input logic [15:0] a, input int unsigned cnt);
        int unsigned win;
        int unsigned bank;
        win = a[14:13];
        if ((m_bank_sel & SEL_PRG_SWAP) != 0)
        begin
            if (win == 0)
                win = 2;
            else if (win == 2)
                win = 0;
        end
        case (win)
            0:       bank = m_banks[6];
            1:       bank = m_banks[7];
            2:       bank = (cnt >= 2) ? cnt - 2 : 0;
            default: bank = cnt - 1;
        endcase
        bank = bank % cnt;
        return 21'(bank * PRG_BANK_BYTES + a[12:0]);
    endfunction

    // Translate a pattern address through the 2 KiB and 1 KiB slots
    function automatic logic [20:0] chr_offset(input logic [15:0] a, input int unsigned cnt);
        logic [2:0]  slot;
        int unsigned bank;
        slot = a[12:10];
        if ((m_bank_sel & SEL_CHR_SWAP) != 0)
            slot = slot ^ 3'd4;
        if (slot < 4)
            bank = (m_banks[slot >> 1] & 8'hFE) | slot[0];
        else
            bank = m_banks[slot - 2];
        bank = bank % cnt;
        return 21'(bank * CHR_BANK_BYTES + a[9:0]);
    endfunction

    // Update mapper registers on a CPU write at 0x8000 and above
    function automatic void mapper_reg_write(input logic [15:0] a, input logic [7:0] d);
        if (a < ADDR_MIRROR)
        begin
            if (!a[0])
                m_bank_sel = d;
            else
                m_banks[m_bank_sel[2:0]] = d;
        end
        else if (a < ADDR_IRQ_LATCH)
        begin
            if (!a[0])
                m_mirror = d[0];
            else
            begin
                m_ram_wp = (d & RAM_CTRL_WP) != 0;
                m_ram_en = (d & RAM_CTRL_EN) != 0;
            end
        end
        else if (a < ADDR_IRQ_DIS)
        begin
            if (!a[0])
                m_irq_latch = d;
            else
            begin
                m_irq_cnt    = '0;
                m_irq_reload = 1'b1;
            end
        end
        else
        begin
            if (!a[0])
            begin
                m_irq_en   = 1'b0;
                m_irq_pend = 1'b0;
            end
            else
                m_irq_en = 1'b1;
        end
    endfunction

    // Reload or decrement the scanline counter, raise the interrupt at zero
    function automatic void scanline_tick();
        if (m_irq_cnt == 0 || m_irq_reload)
        begin
            m_irq_cnt    = m_irq_latch;
            m_irq_reload = 1'b0;
        end
        else
            m_irq_cnt = m_irq_cnt - 8'd1;
        if (m_irq_cnt == 0 && m_irq_en)
            m_irq_pend = 1'b1;
    endfunction

    // Work out the result of one event and advance the mapper copy
    function automatic map_result_t map_event(input logic [2:0] mode, input logic [15:0] a,
                                              input logic [7:0] d);
        map_result_t r;
        int unsigned pcnt;
        int unsigned ccnt;
        logic        ok;
        r    = '0;
        pcnt = (c_prg_count > 256) ? 256 : c_prg_count;
        ccnt = (c_chr_count > 256) ? 256 : c_chr_count;
        case (mode)
            MODE_CPU_RD, MODE_CPU_WR:
            begin
                if (a >= ADDR_RAM_BASE && a < ADDR_BANK_SEL)
                begin
                    ok = c_ram_pres && m_ram_en && !(mode == MODE_CPU_WR && m_ram_wp);
                    if (ok)
                    begin
                        r.target       = TGT_RAM;
                        r.mem_address  = 21'(a - ADDR_RAM_BASE);
                        r.write_strobe = (mode == MODE_CPU_WR);
                    end
                end
                else if (a >= ADDR_BANK_SEL)
                begin
                    if (mode == MODE_CPU_WR)
                        mapper_reg_write(a, d);
                    else if (pcnt != 0)
                    begin
                        r.target      = TGT_PRG;
                        r.mem_address = prg_offset(a, pcnt);
                    end
                end
            end
            MODE_CHR_RD, MODE_CHR_WR:
            begin
                if (ccnt != 0)
                begin
                    r.target       = TGT_CHR;
                    r.mem_address  = chr_offset(a, ccnt);
                    r.write_strobe = (mode == MODE_CHR_WR);
                end
            end
            MODE_TICK:
                scanline_tick();
            default:
                ;
        endcase
        r.irq               = m_irq_pend;
        r.mirror_horizontal = m_mirror;
        return r;
    endfunction

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    // Track configuration beats
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            cfg_writes++;
            case (cfg_index)
                CFG_PRG_COUNT: c_prg_count = cfg_data;
                CFG_CHR_COUNT: c_chr_count = cfg_data;
                CFG_RAM_PRES:  c_ram_pres  = cfg_data[0];
                CFG_INIT_MIR:  m_mirror    = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Predict each accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            due_xlat.push_back(map_event(s_tuser, s_tdata[15:0], s_tdata[23:16]));
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_result
        map_result_t got;
        map_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[20:0], m_tdata[21], m_tdata[22], m_tdata[23]};
            results_seen++;
            target_hits[got.target]++;
            if (got.irq)
                irq_results++;
            if (due_xlat.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing predicted: target %0d addr %h",
                             $realtime, got.target, got.mem_address);
            end
            else
            begin
                want = due_xlat.pop_front();
                if (got.target !== want.target || got.mem_address !== want.mem_address ||
                    got.write_strobe !== want.write_strobe || got.irq !== want.irq ||
                    got.mirror_horizontal !== want.mirror_horizontal)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $write("%0t: result %0d mismatch: exp tgt %0d addr %h wr %b irq %b mir %b",
                               $realtime, results_seen, want.target, want.mem_address,
                               want.write_strobe, want.irq, want.mirror_horizontal);
                        $display(", got tgt %0d addr %h wr %b irq %b mir %b",
                                 got.target, got.mem_address, got.write_strobe, got.irq,
                                 got.mirror_horizontal);
                    end
                end
            end
        end
    end

    // Send one event beat, idling first at the sender rate
    task automatic send_item(input logic [2:0] mode, input logic [15:0] a, input logic [7:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {d, a};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Hold the input until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_xlat.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one configuration register while the block is idle
    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [8:0] prg, input logic [8:0] chr,
                              input logic ram, input logic mir);
        cfg_write(CFG_PRG_COUNT, prg);
        cfg_write(CFG_CHR_COUNT, chr);
        cfg_write(CFG_RAM_PRES, {8'd0, ram});
        cfg_write(CFG_INIT_MIR, {8'd0, mir});
    endtask

    // Program a bank, then fetch through it
    task automatic send_bank_sequence();
        logic [15:0] a;
        int          n;
        a = ADDR_BANK_SEL + 16'($urandom_range(4095) * 2);
        send_item(MODE_CPU_WR, a, 8'($urandom_range(255)));
        send_item(MODE_CPU_WR, a + 16'd1, 8'($urandom_range(255)));
        n = $urandom_range(2, 4);
        repeat (n)
        begin
            if ($urandom_range(1))
                send_item(MODE_CPU_RD, ADDR_BANK_SEL + 16'($urandom_range(16'h7FFF)), 8'h00);
            else
                send_item($urandom_range(1) ? MODE_CHR_WR : MODE_CHR_RD,
                          16'($urandom_range(16'h1FFF)), 8'($urandom_range(255)));
        end
    endtask

    // One random event, weighted toward mapped accesses and counter traffic
    task automatic send_random_item();
        logic [2:0]  mode;
        logic [15:0] a;
        logic [7:0]  d;
        int          r;
        r = $urandom_range(99);
        if (r < 30)
            mode = MODE_CPU_RD;
        else if (r < 55)
            mode = MODE_CPU_WR;
        else if (r < 70)
            mode = MODE_CHR_RD;
        else if (r < 80)
            mode = MODE_CHR_WR;
        else if (r < 95)
            mode = MODE_TICK;
        else
            mode = 3'($urandom_range(MODE_TICK + 1, 7));
        r = $urandom_range(9);
        if (mode == MODE_CHR_RD || mode == MODE_CHR_WR)
            a = (r < 2) ? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(16'h1FFF));
        else if (r < 2)
            a = 16'($urandom_range(16'hFFFF));
        else if (r < 5)
            a = ADDR_RAM_BASE + 16'($urandom_range(16'h1FFF));
        else
            a = ADDR_BANK_SEL + 16'($urandom_range(16'h7FFF));
        d = 8'($urandom_range(255));
        // Keep most latch values small so the counter reaches zero often
        if (a >= ADDR_IRQ_LATCH && a < ADDR_IRQ_DIS && $urandom_range(3) != 0)
            d = 8'($urandom_range(7));
        send_item(mode, a, d);
    endtask

    task automatic send_random_burst(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            if ($urandom_range(9) < 2)
                send_bank_sequence();
            else
                send_random_item();
        end
    endtask

    // Reads and a work-RAM write across every CPU region with the power-on configuration
    task automatic test_cpu_regions();
        send_item(MODE_CPU_RD, 16'h0000, 8'h00);
        send_item(MODE_CPU_RD, 16'h5FFF, 8'h00);
        send_item(MODE_CPU_RD, ADDR_RAM_BASE, 8'h00);
        send_item(MODE_CPU_WR, 16'h7FFF, 8'hFF);
        send_item(MODE_CPU_RD, ADDR_BANK_SEL, 8'h00);
        send_item(MODE_CPU_RD, ADDR_MIRROR, 8'h00);
        send_item(MODE_CPU_RD, ADDR_IRQ_LATCH, 8'h00);
        send_item(MODE_CPU_RD, 16'hFFFF, 8'h00);
    endtask

    // Bank registers with both swap modes, pattern address high bits
    task automatic test_bank_swaps();
        send_item(MODE_CPU_WR, ADDR_BANK_SEL, SEL_PRG_SWAP | 8'd6);
        send_item(MODE_CPU_WR, ADDR_BANK_DATA, 8'hFF);
        send_item(MODE_CPU_RD, ADDR_IRQ_LATCH, 8'h00);
        send_item(MODE_CPU_WR, ADDR_BANK_SEL, SEL_CHR_SWAP | 8'd1);
        send_item(MODE_CPU_WR, ADDR_BANK_DATA, 8'h13);
        send_item(MODE_CHR_RD, 16'h1FFF, 8'h00);
        send_item(MODE_CHR_WR, 16'hFFFF, 8'hA5);
    endtask

    // Mirroring, RAM protect and RAM disable
    task automatic test_ram_control();
        send_item(MODE_CPU_WR, ADDR_MIRROR, 8'h01);
        send_item(MODE_CPU_WR, ADDR_RAM_CTRL, RAM_CTRL_EN | RAM_CTRL_WP);
        send_item(MODE_CPU_WR, ADDR_RAM_BASE, 8'h55);
        send_item(MODE_CPU_RD, ADDR_RAM_BASE, 8'h00);
        send_item(MODE_CPU_WR, ADDR_RAM_CTRL, 8'h00);
        send_item(MODE_CPU_RD, 16'h7FFF, 8'h00);
        send_item(MODE_CPU_WR, ADDR_RAM_CTRL, RAM_CTRL_EN);
    endtask

    // Scanline counter reload, interrupt raise and clear, unused modes
    task automatic test_scanline_irq();
        send_item(MODE_CPU_WR, ADDR_IRQ_LATCH, 8'h02);
        send_item(MODE_CPU_WR, ADDR_IRQ_RELOAD, 8'h00);
        send_item(MODE_CPU_WR, ADDR_IRQ_EN, 8'h00);
        repeat (4) send_item(MODE_TICK, 16'hFFFF, 8'hFF);
        send_item(MODE_CPU_WR, ADDR_IRQ_DIS, 8'h00);
        send_item(MODE_TICK, 16'h0000, 8'h00);
        send_item(3'd5, 16'h8000, 8'hFF);
        send_item(3'd7, 16'hFFFF, 8'h00);
    endtask

    // Sweep configuration extremes: no banks, one bank, oversized counts
    task automatic test_config_extremes();
        set_config(9'd0,   9'd0,   1'b0, 1'b1);
        send_random_burst(40);
        set_config(9'd1,   9'd1,   1'b1, 1'b0);
        send_random_burst(40);
        set_config(9'd2,   9'd256, 1'b1, 1'b1);
        send_random_burst(40);
        set_config(9'd256, 9'd255, 1'b0, 1'b0);
        send_random_burst(40);
        set_config(9'd511, 9'd300, 1'b1, 1'b1);
        send_random_burst(40);
        set_config(9'd3,   9'd5,   1'b1, 1'b0);
        send_random_burst(40);
    endtask

    // Random traffic in three flow-control phases, new setting every chunk
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 65 : 0;
            dst_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 20 : 0;
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                set_config(($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                                    : 9'($urandom_range(2, 64)),
                           ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                                    : 9'($urandom_range(0, 64)),
                           ($urandom_range(4) != 0), 1'($urandom_range(1)));
                send_random_burst(80);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_cpu_regions();
        test_bank_swaps();
        test_ram_control();
        test_scanline_irq();
        test_config_extremes();
        test_random_traffic();
        drain_results();
        errors += due_xlat.size();
        $display("Sent %0d events and %0d config writes, checked %0d results (%0d with irq).",
                 items_sent, cfg_writes, results_seen, irq_results);
        $display("Targets seen: none %0d, prg %0d, ram %0d, chr %0d; mismatches %0d.",
                 target_hits[TGT_NONE], target_hits[TGT_PRG], target_hits[TGT_RAM],
                 target_hits[TGT_CHR], errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
